// ===== hw/rtl/bitmap_page_allocator_core_macros.svh =====
// Assertion macros for the bitmap page allocator.
// Used by bitmap_page_allocator_core; expects clk and rst_n in scope.
`ifndef BITMAP_PAGE_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_CORE_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define BPA_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define BPA_CHECK_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bpa_pkg.sv =====
// Shared types, constants and helpers of the bitmap page allocator.
// No dependencies; used by bpa_req_if, bpa_rsp_if, bpa_scan_step and the core.
`timescale 1ns / 1ps

package bpa_pkg;

  localparam int NUM_PAGES_DEF = 4096;
  localparam int WORD_BITS     = 32;
  localparam int OFF_BITS      = 5;
  localparam int COUNT_W       = 13;
  localparam int PAGE_W        = 12;
  localparam int STATUS_W      = 2;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_ALLOC   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_ROOM = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FREED   = 2'd2;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_RESP
  } state_t;

  typedef enum logic [1:0] {
    STEP_FOUND,
    STEP_NEXT,
    STEP_RESTART,
    STEP_FAIL
  } step_t;

  typedef struct packed {
    step_t      step;
    logic [5:0] run;   // free pages from the offset on
  } scan_res_t;

  // bits lo .. hi-1 of a map word set
  function automatic logic [WORD_BITS-1:0] range_mask(input logic [OFF_BITS-1:0] lo,
                                                      input logic [OFF_BITS:0]   hi);
    logic [WORD_BITS:0]   upper;
    logic [WORD_BITS-1:0] lower;
    upper = ({{WORD_BITS{1'b0}}, 1'b1} << hi) - {{WORD_BITS{1'b0}}, 1'b1};
    lower = {WORD_BITS{1'b1}} << lo;
    return upper[WORD_BITS-1:0] & lower;
  endfunction

endpackage

// ===== hw/rtl/bpa_req_if.sv =====
// Request channel of the bitmap page allocator: valid/ready plus request word.
// Depends on bpa_pkg for field widths.
`timescale 1ns / 1ps

interface bpa_req_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [bpa_pkg::COUNT_W-1:0]  run_pages;
  logic [bpa_pkg::PAGE_W-1:0]   start_page;

  modport source (output valid, kind, run_pages, start_page, input ready);
  modport sink   (input valid, kind, run_pages, start_page, output ready);
endinterface

// ===== hw/rtl/bpa_rsp_if.sv =====
// Response channel of the bitmap page allocator: valid/ready plus result word.
// Depends on bpa_pkg for field widths.
`timescale 1ns / 1ps

interface bpa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bpa_pkg::STATUS_W-1:0]  status;
  logic [bpa_pkg::PAGE_W-1:0]    first_page;

  modport source (output valid, status, first_page, input ready);
  modport sink   (input valid, status, first_page, output ready);
endinterface

// ===== hw/rtl/bpa_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
`timescale 1ns / 1ps

module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/bpa_scan_step.sv =====
// One step of the first-fit search over a single 32-page map word.
// Depends on bpa_pkg (scan_res_t, step_t).
`timescale 1ns / 1ps

module bpa_scan_step (
  input  logic [bpa_pkg::WORD_BITS-1:0] map_word,
  input  logic [bpa_pkg::OFF_BITS-1:0]  off,
  input  logic [bpa_pkg::OFF_BITS:0]    lim,      // pages of this word inside the heap
  input  logic [bpa_pkg::COUNT_W-1:0]   run_len,
  input  logic [bpa_pkg::COUNT_W-1:0]   count,
  output bpa_pkg::scan_res_t            res
);

  logic [bpa_pkg::WORD_BITS-1:0] free_bits;
  logic [bpa_pkg::WORD_BITS-1:0] shifted;
  logic [5:0]                    ones;
  logic [bpa_pkg::COUNT_W:0]     reach;
  logic [6:0]                    stop;

  always_comb begin
    for (int i = 0; i < bpa_pkg::WORD_BITS; i++) begin
      free_bits[i] = !map_word[i] && (7'(i) < {1'b0, lim});
    end
    shifted = free_bits >> off;
    // trailing ones = index of the lowest used (or outside) page
    ones = 6'd32;
    for (int i = bpa_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (!shifted[i]) begin
        ones = 6'(i);
      end
    end
    reach = {1'b0, run_len} + 14'(ones);
    stop  = {2'b00, off} + {1'b0, ones};

    res.run = ones;
    if (reach >= {1'b0, count}) begin
      res.step = bpa_pkg::STEP_FOUND;
    end else if (stop == 7'd32) begin
      res.step = bpa_pkg::STEP_NEXT;
    end else if (stop >= {1'b0, lim}) begin
      res.step = bpa_pkg::STEP_FAIL;
    end else begin
      res.step = bpa_pkg::STEP_RESTART;
    end
  end

endmodule

// ===== hw/rtl/bitmap_page_allocator_core.sv =====
// Bitmap first-fit page allocator: usage map in a word RAM, search hint, sequencer.
// Depends on bpa_pkg, bpa_req_if, bpa_rsp_if, bpa_ram, bpa_scan_step and the macro header.
//
// Usage: in_req carries one request word (kind, run_pages, start_page); out_rsp
// returns exactly one word (status, first_page) per request, in order. Both are
// valid/ready channels; a word moves when valid and ready are high at a clock edge.
// One request is worked on at a time; in_req.ready is high only while idle.
// Map is held 32 pages per RAM word. After rst_n the map is zeroed by a clearing
// pass of one word per cycle; no request is taken during it. An allocate is
// accepted in idle, then scans one map word per step plus one step per used page
// that breaks a candidate run inside a word, then marks each word of the run, then
// moves to the result register. A free is accepted, clears each word of its range
// and moves to the result register. Zero-page and hint-at-end allocates skip the
// scan. The scan step unit and the single RAM read port set this pace.
// The result register lets a new request start while the previous result is held;
// if the receiver stalls, the finished result waits in the sequencer until the
// result register frees up.
`timescale 1ns / 1ps
`include "bitmap_page_allocator_core_macros.svh"

module bitmap_page_allocator_core #(
  parameter int NUM_PAGES = bpa_pkg::NUM_PAGES_DEF
) (
  input logic          clk,
  input logic          rst_n,
  bpa_req_if.sink      in_req,
  bpa_rsp_if.source    out_rsp
);

  localparam int WB    = bpa_pkg::WORD_BITS;
  localparam int OB    = bpa_pkg::OFF_BITS;
  localparam int CW    = bpa_pkg::COUNT_W;
  localparam int PW    = bpa_pkg::PAGE_W;
  localparam int DEPTH = (NUM_PAGES + WB - 1) / WB;
  localparam int SPAN  = DEPTH * WB;
  localparam int SW    = $clog2(SPAN + 1);
  localparam int HW    = $clog2(NUM_PAGES + 1);
  localparam int WW    = SW - OB;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int XW    = (SW > CW ? SW : CW) + 1;

  bpa_pkg::state_t state_r, state_nxt;

  logic [SW-1:0]                 pos_r, pos_nxt;
  logic [SW-1:0]                 run_start_r, run_start_nxt;
  logic [CW-1:0]                 len_r, len_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [HW-1:0]                 hint_r, hint_nxt;
  logic [WW-1:0]                 mw_r, mw_nxt;
  logic [SW-1:0]                 mk_lo_r, mk_lo_nxt;
  logic [SW-1:0]                 mk_hi_r, mk_hi_nxt;
  logic                          mk_set_r, mk_set_nxt;
  logic [bpa_pkg::STATUS_W-1:0]  pend_status_r, pend_status_nxt;
  logic [PW-1:0]                 pend_first_r, pend_first_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [bpa_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [PW-1:0]                 out_first_r, out_first_nxt;

  logic                          in_ready;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic [WB-1:0]                 wr_data;
  logic [WW-1:0]                 rd_word;
  logic [WB-1:0]                 rd_data;

  logic [SW-1:0]                 base;
  logic [SW-1:0]                 rem;
  logic                          past_end;
  logic [OB:0]                   lim;
  bpa_pkg::scan_res_t            scan_res;
  logic [SW-1:0]                 run_end;

  logic [XW-1:0]                 start_x;
  logic [XW-1:0]                 sum_x;
  logic [XW-1:0]                 end_x;
  logic                          in_heap;

  logic [SW-1:0]                 hi_m1;
  logic [WW-1:0]                 mk_last;
  logic [OB-1:0]                 mk_off_lo;
  logic [OB:0]                   mk_off_hi;
  logic [WB-1:0]                 mk_mask;

  bpa_ram #(
    .WIDTH (WB),
    .DEPTH (DEPTH)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_word[AW-1:0]),
    .rd_data (rd_data)
  );

  // word geometry of the current scan position
  assign base     = {pos_r[SW-1:OB], {OB{1'b0}}};
  assign past_end = base >= SW'(NUM_PAGES);
  assign rem      = SW'(NUM_PAGES) - base;
  assign lim      = past_end ? '0 : ((rem >= SW'(WB)) ? (OB+1)'(WB) : rem[OB:0]);
  assign run_end  = run_start_r + SW'(cnt_r);

  bpa_scan_step u_step (
    .map_word (rd_data),
    .off      (pos_r[OB-1:0]),
    .lim      (lim),
    .run_len  (len_r),
    .count    (cnt_r),
    .res      (scan_res)
  );

  // free range, clipped at the heap end
  assign start_x = XW'(in_req.start_page);
  assign sum_x   = start_x + XW'(in_req.run_pages);
  assign in_heap = start_x < XW'(NUM_PAGES);
  assign end_x   = (sum_x > XW'(NUM_PAGES)) ? XW'(NUM_PAGES) : sum_x;

  // mask of the marked range inside the current word
  assign hi_m1     = mk_hi_r - SW'(1);
  assign mk_last   = hi_m1[SW-1:OB];
  assign mk_off_lo = (mk_lo_r[SW-1:OB] == mw_r) ? mk_lo_r[OB-1:0] : '0;
  assign mk_off_hi = (mk_hi_r[SW-1:OB] == mw_r) ? {1'b0, mk_hi_r[OB-1:0]} : (OB+1)'(WB);
  assign mk_mask   = bpa_pkg::range_mask(mk_off_lo, mk_off_hi);

  assign in_req.ready       = in_ready;
  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.status     = out_status_r;
  assign out_rsp.first_page = out_first_r;

  always_comb begin
    state_nxt       = state_r;
    pos_nxt         = pos_r;
    run_start_nxt   = run_start_r;
    len_nxt         = len_r;
    cnt_nxt         = cnt_r;
    hint_nxt        = hint_r;
    mw_nxt          = mw_r;
    mk_lo_nxt       = mk_lo_r;
    mk_hi_nxt       = mk_hi_r;
    mk_set_nxt      = mk_set_r;
    pend_status_nxt = pend_status_r;
    pend_first_nxt  = pend_first_r;
    out_valid_nxt   = out_valid_r && !out_rsp.ready;
    out_status_nxt  = out_status_r;
    out_first_nxt   = out_first_r;
    in_ready        = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = mw_r[AW-1:0];
    wr_data         = '0;

    case (state_r)
      bpa_pkg::ST_CLR: begin
        wr_en = 1'b1;
        if (mw_r == WW'(DEPTH - 1)) begin
          mw_nxt    = '0;
          state_nxt = bpa_pkg::ST_IDLE;
        end else begin
          mw_nxt = mw_r + WW'(1);
        end
      end

      bpa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_req.valid) begin
          cnt_nxt = in_req.run_pages;
          if (in_req.kind == bpa_pkg::KIND_FREE) begin
            pend_status_nxt = bpa_pkg::STATUS_FREED;
            pend_first_nxt  = '0;
            state_nxt       = bpa_pkg::ST_RESP;
            if (in_heap) begin
              if (start_x < XW'(hint_r)) begin
                hint_nxt = HW'(start_x);
              end
              if (end_x > start_x) begin
                mk_lo_nxt  = SW'(start_x);
                mk_hi_nxt  = SW'(end_x);
                mk_set_nxt = 1'b0;
                mw_nxt     = WW'(start_x >> OB);
                state_nxt  = bpa_pkg::ST_MARK;
              end
            end
          end else if (hint_r == HW'(NUM_PAGES)) begin
            pend_status_nxt = bpa_pkg::STATUS_NO_ROOM;
            pend_first_nxt  = '0;
            state_nxt       = bpa_pkg::ST_RESP;
          end else if (in_req.run_pages == '0) begin
            pend_status_nxt = bpa_pkg::STATUS_ALLOC;
            pend_first_nxt  = PW'(hint_r);
            state_nxt       = bpa_pkg::ST_RESP;
          end else begin
            pos_nxt       = SW'(hint_r);
            run_start_nxt = SW'(hint_r);
            len_nxt       = '0;
            state_nxt     = bpa_pkg::ST_SCAN;
          end
        end
      end

      bpa_pkg::ST_SCAN: begin
        if (past_end) begin
          pend_status_nxt = bpa_pkg::STATUS_NO_ROOM;
          pend_first_nxt  = '0;
          state_nxt       = bpa_pkg::ST_RESP;
        end else begin
          case (scan_res.step)
            bpa_pkg::STEP_FOUND: begin
              pend_status_nxt = bpa_pkg::STATUS_ALLOC;
              pend_first_nxt  = PW'(run_start_r);
              if (SW'(hint_r) == run_start_r) begin
                hint_nxt = HW'(run_end);
              end
              mk_lo_nxt  = run_start_r;
              mk_hi_nxt  = run_end;
              mk_set_nxt = 1'b1;
              mw_nxt     = run_start_r[SW-1:OB];
              state_nxt  = bpa_pkg::ST_MARK;
            end
            bpa_pkg::STEP_NEXT: begin
              len_nxt = len_r + CW'(scan_res.run);
              pos_nxt = {pos_r[SW-1:OB] + WW'(1), {OB{1'b0}}};
            end
            bpa_pkg::STEP_RESTART: begin
              // skip past the used page, fresh candidate run
              len_nxt       = '0;
              pos_nxt       = pos_r + SW'(scan_res.run) + SW'(1);
              run_start_nxt = pos_r + SW'(scan_res.run) + SW'(1);
            end
            bpa_pkg::STEP_FAIL: begin
              pend_status_nxt = bpa_pkg::STATUS_NO_ROOM;
              pend_first_nxt  = '0;
              state_nxt       = bpa_pkg::ST_RESP;
            end
            default: begin
              state_nxt = bpa_pkg::ST_SCAN;
            end
          endcase
        end
      end

      bpa_pkg::ST_MARK: begin
        wr_en   = 1'b1;
        wr_data = mk_set_r ? (rd_data | mk_mask) : (rd_data & ~mk_mask);
        if (mw_r == mk_last) begin
          state_nxt = bpa_pkg::ST_RESP;
        end else begin
          mw_nxt = mw_r + WW'(1);
        end
      end

      bpa_pkg::ST_RESP: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pend_status_r;
          out_first_nxt  = pend_first_r;
          state_nxt      = bpa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = bpa_pkg::ST_IDLE;
      end
    endcase

    // read one word ahead so data lines up with the next cycle's position
    rd_word = (state_nxt == bpa_pkg::ST_MARK) ? mw_nxt : pos_nxt[SW-1:OB];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpa_pkg::ST_CLR;
      mw_r        <= '0;
      hint_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mw_r        <= mw_nxt;
      hint_r      <= hint_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r         <= pos_nxt;
    run_start_r   <= run_start_nxt;
    len_r         <= len_nxt;
    cnt_r         <= cnt_nxt;
    mk_lo_r       <= mk_lo_nxt;
    mk_hi_r       <= mk_hi_nxt;
    mk_set_r      <= mk_set_nxt;
    pend_status_r <= pend_status_nxt;
    pend_first_r  <= pend_first_nxt;
    out_status_r  <= out_status_nxt;
    out_first_r   <= out_first_nxt;
  end

  `BPA_CHECK(a_hint_range, hint_r <= HW'(NUM_PAGES), "search hint beyond heap end")
  `BPA_CHECK_IMPL(a_scan_len, state_r == bpa_pkg::ST_SCAN, len_r < cnt_r,
                  "run length reached request during scan")
  `BPA_CHECK_IMPL(a_found_fits,
                  (state_r == bpa_pkg::ST_SCAN) && !past_end &&
                  (scan_res.step == bpa_pkg::STEP_FOUND),
                  (XW'(run_start_r) + XW'(cnt_r)) <= XW'(NUM_PAGES),
                  "found run passes heap end")
  `BPA_CHECK_IMPL(a_mark_span, state_r == bpa_pkg::ST_MARK,
                  (mw_r >= mk_lo_r[SW-1:OB]) && (mw_r <= mk_last), "mark word outside run")
  `BPA_CHECK_IMPL(a_clr_quiet, state_r == bpa_pkg::ST_CLR, !in_ready && !out_valid_r,
                  "activity during map clear")

endmodule
